>>> rtl/tdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdm_pkg
// Shared constants, types and elaboration helpers of the two-level tag store.
// ----------------------------------------------------------------------------
package tdm_pkg;

  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;

  // access kind codes
  localparam logic FUNC_INST = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // outcome of one lookup, handed to the statistics block
  typedef struct packed {
    logic fire;
    logic is_data;
    logic l1_hit;
    logic l2_checked;
    logic l2_hit;
  } tdm_event_t;

  // largest n with 2**n <= v; a set count that is not a power of two rounds down
  function automatic int floor_log2(input longint unsigned v);
    int n;
    n = 0;
    for (int b = 1; b < 64; b++) begin
      if (v >= (64'd1 << b)) n = b;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/two_level_direct_mapped_tag_store_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_direct_mapped_tag_store_unit
// Tag store of a split direct-mapped L1 (instruction/data) over a shared L2.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. The selected L1 and
// L2 tag RAMs are read at that edge; in the next cycle the tags are compared
// and any fill is written back, and in the cycle after that out_valid pulses
// for one cycle with the hit flags and the running totals. busy is high only
// during the compare cycle and the clearing pass, so a new access can be
// started in the same cycle as the strobe, but not while the previous one is
// being compared and written back. Results cannot be stalled.
// After reset a clearing pass writes every tag RAM entry invalid, with busy
// held high throughout; each set count is rounded down to a power of two.
module two_level_direct_mapped_tag_store_unit #(
  parameter int LINE_BYTES = 64,
  parameter int L1I_SETS   = 512,
  parameter int L1D_SETS   = 512,
  parameter int L2_SETS    = 8192
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_func,
  input  wire logic [tdm_pkg::ADDR_W-1:0]   in_address,
  output logic                              out_valid,
  output logic                              out_l1_hit,
  output logic                              out_l2_checked,
  output logic                              out_l2_hit,
  output logic [tdm_pkg::CNT_W-1:0]         out_l1_hit_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_l1_miss_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_l2_hit_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_l2_miss_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_access_total
);

  localparam int OFF_W = tdm_pkg::floor_log2(64'(LINE_BYTES));
  localparam int IX_I  = tdm_pkg::floor_log2(64'(L1I_SETS));
  localparam int IX_D  = tdm_pkg::floor_log2(64'(L1D_SETS));
  localparam int IX_2  = tdm_pkg::floor_log2(64'(L2_SETS));
  localparam int TG_I  = tdm_pkg::ADDR_W - OFF_W - IX_I;
  localparam int TG_D  = tdm_pkg::ADDR_W - OFF_W - IX_D;
  localparam int TG_2  = tdm_pkg::ADDR_W - OFF_W - IX_2;
  localparam int CLR_W = (IX_2 > IX_I) ? ((IX_2 > IX_D) ? IX_2 : IX_D)
                                       : ((IX_I > IX_D) ? IX_I : IX_D);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [CLR_W-1:0]             clr_r, clr_nxt;
  logic                         func_r;
  logic [tdm_pkg::ADDR_W-1:0]   addr_r;
  logic                         accept;

  logic [tdm_pkg::ADDR_W-1:0]   sel_addr;
  logic [IX_I-1:0]              a_i;
  logic [IX_D-1:0]              a_d;
  logic [IX_2-1:0]              a_2;
  logic                         we_i, we_d, we_2;
  logic [TG_I:0]                wd_i, rd_i;
  logic [TG_D:0]                wd_d, rd_d;
  logic [TG_2:0]                wd_2, rd_2;
  logic                         hit_i, hit_d, hit_2, l1_hit;
  logic                         clearing, looking;
  tdm_pkg::tdm_event_t          ev;

  assign busy     = state_r != ST_IDLE;
  assign accept   = start && !busy;
  assign clearing = state_r == ST_CLEAR;
  assign looking  = state_r == ST_LOOK;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + {{(CLR_W-1){1'b0}}, 1'b1};
        if (clr_r == {CLR_W{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // hold the transaction for the compare cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      addr_r <= in_address;
    end
  end

  // read from the incoming address, write back at the held one
  assign sel_addr = looking ? addr_r : in_address;
  assign a_i = clearing ? clr_r[IX_I-1:0] : sel_addr[OFF_W +: IX_I];
  assign a_d = clearing ? clr_r[IX_D-1:0] : sel_addr[OFF_W +: IX_D];
  assign a_2 = clearing ? clr_r[IX_2-1:0] : sel_addr[OFF_W +: IX_2];

  // valid bit sits on top of each tag word
  assign hit_i = rd_i[TG_I] && (rd_i[TG_I-1:0] == addr_r[tdm_pkg::ADDR_W-1 -: TG_I]);
  assign hit_d = rd_d[TG_D] && (rd_d[TG_D-1:0] == addr_r[tdm_pkg::ADDR_W-1 -: TG_D]);
  assign hit_2 = rd_2[TG_2] && (rd_2[TG_2-1:0] == addr_r[tdm_pkg::ADDR_W-1 -: TG_2]);
  assign l1_hit = (func_r == tdm_pkg::FUNC_DATA) ? hit_d : hit_i;

  assign we_i = clearing || (looking && func_r == tdm_pkg::FUNC_INST && !l1_hit);
  assign we_d = clearing || (looking && func_r == tdm_pkg::FUNC_DATA && !l1_hit);
  assign we_2 = clearing || (looking && !l1_hit && !hit_2);

  assign wd_i = clearing ? '0 : {1'b1, addr_r[tdm_pkg::ADDR_W-1 -: TG_I]};
  assign wd_d = clearing ? '0 : {1'b1, addr_r[tdm_pkg::ADDR_W-1 -: TG_D]};
  assign wd_2 = clearing ? '0 : {1'b1, addr_r[tdm_pkg::ADDR_W-1 -: TG_2]};

  tdm_ram #(.WIDTH(TG_I + 1), .DEPTH(1 << IX_I)) u_l1i_tags (
    .clk   (clk),
    .addr  (a_i),
    .we    (we_i),
    .wdata (wd_i),
    .rdata (rd_i)
  );

  tdm_ram #(.WIDTH(TG_D + 1), .DEPTH(1 << IX_D)) u_l1d_tags (
    .clk   (clk),
    .addr  (a_d),
    .we    (we_d),
    .wdata (wd_d),
    .rdata (rd_d)
  );

  tdm_ram #(.WIDTH(TG_2 + 1), .DEPTH(1 << IX_2)) u_l2_tags (
    .clk   (clk),
    .addr  (a_2),
    .we    (we_2),
    .wdata (wd_2),
    .rdata (rd_2)
  );

  always_comb begin
    ev.fire       = looking;
    ev.is_data    = func_r;
    ev.l1_hit     = l1_hit;
    ev.l2_checked = !l1_hit;
    ev.l2_hit     = !l1_hit && hit_2;
  end

  tdm_stats u_stats (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev                (ev),
    .out_valid         (out_valid),
    .out_l1_hit        (out_l1_hit),
    .out_l2_checked    (out_l2_checked),
    .out_l2_hit        (out_l2_hit),
    .out_l1_hit_total  (out_l1_hit_total),
    .out_l1_miss_total (out_l1_miss_total),
    .out_l2_hit_total  (out_l2_hit_total),
    .out_l2_miss_total (out_l2_miss_total),
    .out_access_total  (out_access_total)
  );

endmodule
`default_nettype wire

>>> rtl/tdm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> rtl/tdm_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdm_stats
// Hit and miss counters, and the registered result strobe with its totals.
// ----------------------------------------------------------------------------
module tdm_stats (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tdm_pkg::tdm_event_t          ev,
  output logic                              out_valid,
  output logic                              out_l1_hit,
  output logic                              out_l2_checked,
  output logic                              out_l2_hit,
  output logic [tdm_pkg::CNT_W-1:0]         out_l1_hit_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_l1_miss_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_l2_hit_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_l2_miss_total,
  output logic [tdm_pkg::CNT_W-1:0]         out_access_total
);

  logic [tdm_pkg::CNT_W-1:0] i_hit_r, i_miss_r, d_hit_r, d_miss_r;
  logic [tdm_pkg::CNT_W-1:0] l2_hit_r, l2_miss_r, acc_r;
  logic [tdm_pkg::CNT_W-1:0] i_hit_nxt, i_miss_nxt, d_hit_nxt, d_miss_nxt;
  logic [tdm_pkg::CNT_W-1:0] l2_hit_nxt, l2_miss_nxt, acc_nxt;
  logic                      is_i, is_d;

  assign is_d = ev.is_data == tdm_pkg::FUNC_DATA;
  assign is_i = !is_d;

  always_comb begin
    i_hit_nxt   = i_hit_r   + {{(tdm_pkg::CNT_W-1){1'b0}}, is_i && ev.l1_hit};
    i_miss_nxt  = i_miss_r  + {{(tdm_pkg::CNT_W-1){1'b0}}, is_i && !ev.l1_hit};
    d_hit_nxt   = d_hit_r   + {{(tdm_pkg::CNT_W-1){1'b0}}, is_d && ev.l1_hit};
    d_miss_nxt  = d_miss_r  + {{(tdm_pkg::CNT_W-1){1'b0}}, is_d && !ev.l1_hit};
    l2_hit_nxt  = l2_hit_r  + {{(tdm_pkg::CNT_W-1){1'b0}}, ev.l2_checked && ev.l2_hit};
    l2_miss_nxt = l2_miss_r + {{(tdm_pkg::CNT_W-1){1'b0}}, ev.l2_checked && !ev.l2_hit};
    acc_nxt     = acc_r + {{(tdm_pkg::CNT_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_hit_r   <= '0;
      i_miss_r  <= '0;
      d_hit_r   <= '0;
      d_miss_r  <= '0;
      l2_hit_r  <= '0;
      l2_miss_r <= '0;
      acc_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ev.fire;
      if (ev.fire) begin
        i_hit_r   <= i_hit_nxt;
        i_miss_r  <= i_miss_nxt;
        d_hit_r   <= d_hit_nxt;
        d_miss_r  <= d_miss_nxt;
        l2_hit_r  <= l2_hit_nxt;
        l2_miss_r <= l2_miss_nxt;
        acc_r     <= acc_nxt;
      end
    end
  end

  // result payload: totals after this transaction
  always_ff @(posedge clk) begin
    if (ev.fire) begin
      out_l1_hit        <= ev.l1_hit;
      out_l2_checked    <= ev.l2_checked;
      out_l2_hit        <= ev.l2_hit;
      out_l1_hit_total  <= is_d ? d_hit_nxt : i_hit_nxt;
      out_l1_miss_total <= is_d ? d_miss_nxt : i_miss_nxt;
      out_l2_hit_total  <= l2_hit_nxt;
      out_l2_miss_total <= l2_miss_nxt;
      out_access_total  <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sim/two_level_direct_mapped_tag_store_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_direct_mapped_tag_store_unit_test
// Checks the split L1I/L1D over L2 tag store against a cycle-free lookup
// model: every accepted access is looked up in the model, and each strobed
// result is compared field by field with the oldest outstanding report.
// Directed accesses cover the address extremes and conflict cases; the random
// part mostly reuses a small pool of lines so that hits, evictions and
// back-to-back same-index fills occur often.
// ----------------------------------------------------------------------------
module two_level_direct_mapped_tag_store_unit_test;

  localparam int LINE_BYTES = 64;
  localparam int L1I_SETS   = 512;
  localparam int L1D_SETS   = 512;
  localparam int L2_SETS    = 8192;

  localparam int ADDR_W    = tdm_pkg::ADDR_W;
  localparam int CNT_W     = tdm_pkg::CNT_W;
  localparam int OFF_W     = $clog2(LINE_BYTES);
  localparam int L1I_IDX_W = $clog2(L1I_SETS);
  localparam int L1D_IDX_W = $clog2(L1D_SETS);
  localparam int L2_IDX_W  = $clog2(L2_SETS);
  localparam int L1I_TAG_W = ADDR_W - OFF_W - L1I_IDX_W;
  localparam int L1D_TAG_W = ADDR_W - OFF_W - L1D_IDX_W;
  localparam int L2_TAG_W  = ADDR_W - OFF_W - L2_IDX_W;

  localparam int RANDOM_ACCESSES = 1650;
  localparam int POOL_LINES      = 32;
  localparam int CALM_FIRST      = 700;
  localparam int CALM_LAST       = 1000;

  typedef struct {
    logic              func;
    logic [ADDR_W-1:0] address;
  } access_t;

  typedef struct {
    logic             l1_hit;
    logic             l2_checked;
    logic             l2_hit;
    logic [CNT_W-1:0] l1_hit_total;
    logic [CNT_W-1:0] l1_miss_total;
    logic [CNT_W-1:0] l2_hit_total;
    logic [CNT_W-1:0] l2_miss_total;
    logic [CNT_W-1:0] access_total;
  } access_report_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              start      = 1'b0;
  logic              in_func    = tdm_pkg::FUNC_INST;
  logic [ADDR_W-1:0] in_address = '0;
  logic              busy;
  logic              out_valid;
  logic              out_l1_hit;
  logic              out_l2_checked;
  logic              out_l2_hit;
  logic [CNT_W-1:0]  out_l1_hit_total;
  logic [CNT_W-1:0]  out_l1_miss_total;
  logic [CNT_W-1:0]  out_l2_hit_total;
  logic [CNT_W-1:0]  out_l2_miss_total;
  logic [CNT_W-1:0]  out_access_total;

  two_level_direct_mapped_tag_store_unit #(
    .LINE_BYTES(LINE_BYTES),
    .L1I_SETS  (L1I_SETS),
    .L1D_SETS  (L1D_SETS),
    .L2_SETS   (L2_SETS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_l1_hit       (out_l1_hit),
    .out_l2_checked   (out_l2_checked),
    .out_l2_hit       (out_l2_hit),
    .out_l1_hit_total (out_l1_hit_total),
    .out_l1_miss_total(out_l1_miss_total),
    .out_l2_hit_total (out_l2_hit_total),
    .out_l2_miss_total(out_l2_miss_total),
    .out_access_total (out_access_total)
  );

  always #2 clk = ~clk;

  // model state of the three tag stores and the counters
  bit                 l1i_valid [L1I_SETS];
  bit [L1I_TAG_W-1:0] l1i_tag   [L1I_SETS];
  bit                 l1d_valid [L1D_SETS];
  bit [L1D_TAG_W-1:0] l1d_tag   [L1D_SETS];
  bit                 l2_valid  [L2_SETS];
  bit [L2_TAG_W-1:0]  l2_tag    [L2_SETS];
  bit [CNT_W-1:0]     l1i_hits, l1i_misses, l1d_hits, l1d_misses;
  bit [CNT_W-1:0]     l2_hits, l2_misses, accesses;

  access_t        access_backlog[$];
  access_report_t pending_reports[$];
  logic           took_access = 1'b0;
  int             offered     = 0;
  int             fault_count = 0;

  function automatic access_report_t lookup_hierarchy(input logic func,
                                                      input logic [ADDR_W-1:0] addr);
    access_report_t      rep;
    logic                is_data;
    logic                hit1;
    logic [L1I_IDX_W-1:0] ii;
    logic [L1I_TAG_W-1:0] ti;
    logic [L1D_IDX_W-1:0] id;
    logic [L1D_TAG_W-1:0] td;
    logic [L2_IDX_W-1:0]  i2;
    logic [L2_TAG_W-1:0]  t2;
    is_data = (func == tdm_pkg::FUNC_DATA);
    ii = addr[OFF_W +: L1I_IDX_W];
    ti = addr[ADDR_W-1 : OFF_W + L1I_IDX_W];
    id = addr[OFF_W +: L1D_IDX_W];
    td = addr[ADDR_W-1 : OFF_W + L1D_IDX_W];
    i2 = addr[OFF_W +: L2_IDX_W];
    t2 = addr[ADDR_W-1 : OFF_W + L2_IDX_W];
    hit1 = is_data ? (l1d_valid[id] && l1d_tag[id] == td)
                   : (l1i_valid[ii] && l1i_tag[ii] == ti);
    rep.l1_hit     = hit1;
    rep.l2_checked = !hit1;
    rep.l2_hit     = 1'b0;
    if (hit1) begin
      if (is_data) l1d_hits++;
      else l1i_hits++;
    end else begin
      if (is_data) l1d_misses++;
      else l1i_misses++;
      rep.l2_hit = l2_valid[i2] && l2_tag[i2] == t2;
      if (rep.l2_hit) begin
        l2_hits++;
      end else begin
        l2_misses++;
        l2_valid[i2] = 1'b1;
        l2_tag[i2]   = t2;
      end
      // fill the selected L1 on every miss
      if (is_data) begin
        l1d_valid[id] = 1'b1;
        l1d_tag[id]   = td;
      end else begin
        l1i_valid[ii] = 1'b1;
        l1i_tag[ii]   = ti;
      end
    end
    accesses++;
    rep.l1_hit_total  = is_data ? l1d_hits : l1i_hits;
    rep.l1_miss_total = is_data ? l1d_misses : l1i_misses;
    rep.l2_hit_total  = l2_hits;
    rep.l2_miss_total = l2_misses;
    rep.access_total  = accesses;
    return rep;
  endfunction

  task automatic note_field(input string name, input logic [CNT_W-1:0] want,
                            input logic [CNT_W-1:0] got);
    if (got !== want) begin
      if (fault_count < 10)
        $display("mismatch on %s at %0t: expected %h, got %h", name, $realtime, want, got);
      fault_count++;
    end
  endtask

  task automatic compare_report(input access_report_t want);
    note_field("l1_hit", CNT_W'(want.l1_hit), CNT_W'(out_l1_hit));
    note_field("l2_checked", CNT_W'(want.l2_checked), CNT_W'(out_l2_checked));
    note_field("l2_hit", CNT_W'(want.l2_hit), CNT_W'(out_l2_hit));
    note_field("l1_hit_total", want.l1_hit_total, out_l1_hit_total);
    note_field("l1_miss_total", want.l1_miss_total, out_l1_miss_total);
    note_field("l2_hit_total", want.l2_hit_total, out_l2_hit_total);
    note_field("l2_miss_total", want.l2_miss_total, out_l2_miss_total);
    note_field("access_total", want.access_total, out_access_total);
  endtask

  // monitor: check the strobed result first, then log the transaction taken here
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_reports.size() == 0) begin
          if (fault_count < 10) $display("unexpected result at %0t", $realtime);
          fault_count++;
        end else begin
          compare_report(pending_reports.pop_front());
        end
      end
      if (start && busy === 1'b0)
        pending_reports.push_back(lookup_hierarchy(in_func, in_address));
    end
    took_access <= rst_n && start && busy === 1'b0;
  end

  // driver: hold a transaction until it is taken, then offer the next or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !took_access)) begin
      if (access_backlog.size() != 0 &&
          ((offered >= CALM_FIRST && offered < CALM_LAST) || $urandom_range(0, 99) >= 35)) begin
        access_t a;
        a = access_backlog.pop_front();
        in_func    <= a.func;
        in_address <= a.address;
        start      <= 1'b1;
        offered++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_access(input logic func, input logic [ADDR_W-1:0] addr);
    access_t a;
    a.func    = func;
    a.address = addr;
    access_backlog.push_back(a);
  endtask

  initial begin
    logic [ADDR_W-1:0] pool [POOL_LINES];
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] last_addr;
    logic              func;
    int                pick;

    // cold miss, then hits within the same line at both offset extremes
    queue_access(tdm_pkg::FUNC_INST, 64'h0);
    queue_access(tdm_pkg::FUNC_INST, 64'h3F);
    // data side misses its own L1 but finds the line in L2
    queue_access(tdm_pkg::FUNC_DATA, 64'h0);
    queue_access(tdm_pkg::FUNC_DATA, 64'h20);
    queue_access(tdm_pkg::FUNC_INST, '1);
    queue_access(tdm_pkg::FUNC_DATA, '1);
    queue_access(tdm_pkg::FUNC_INST, '1);
    // same L1 index, different L2 index: evict L1 only
    queue_access(tdm_pkg::FUNC_INST, 64'h8000);
    queue_access(tdm_pkg::FUNC_INST, 64'h0);
    // same L1 and L2 index, new tag: evict both
    queue_access(tdm_pkg::FUNC_INST, 64'h80000);
    queue_access(tdm_pkg::FUNC_INST, 64'h0);
    // L1D still holds line 0, untouched by the instruction-side evictions
    queue_access(tdm_pkg::FUNC_DATA, 64'h0);
    queue_access(tdm_pkg::FUNC_DATA, 64'h8000_0000_0000_0000);
    queue_access(tdm_pkg::FUNC_DATA, 64'h7FFF_FFFF_FFFF_FFC0);
    queue_access(tdm_pkg::FUNC_DATA, 64'h8000_0000_0000_0000);
    queue_access(tdm_pkg::FUNC_INST, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_access(tdm_pkg::FUNC_DATA, 64'h5555_5555_5555_5555);
    // back-to-back fills into one index
    queue_access(tdm_pkg::FUNC_DATA, 64'h1234_0000_0000_1040);
    queue_access(tdm_pkg::FUNC_DATA, 64'h4321_0000_0000_1040);
    queue_access(tdm_pkg::FUNC_DATA, 64'h1234_0000_0000_1040);
    queue_access(tdm_pkg::FUNC_DATA, 64'h1234_0000_0000_1040);

    for (int p = 0; p < POOL_LINES; p++) begin
      pool[p] = {$urandom, $urandom};
      pool[p][OFF_W-1:0] = '0;
    end
    last_addr = pool[0];
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      func = $urandom_range(0, 1) ? tdm_pkg::FUNC_DATA : tdm_pkg::FUNC_INST;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        addr = pool[$urandom_range(0, POOL_LINES - 1)];
      end else if (pick < 80) begin
        // alias a pool line: same L1 index, maybe same L2 index, usually another tag
        addr = pool[$urandom_range(0, POOL_LINES - 1)];
        addr[16:15] = 2'($urandom_range(0, 3));
        addr[20:19] = 2'($urandom_range(0, 3));
      end else if (pick < 92) begin
        addr = last_addr + ADDR_W'(LINE_BYTES);
      end else begin
        addr = {$urandom, $urandom};
      end
      if (pick < 92) addr[OFF_W-1:0] = OFF_W'($urandom_range(0, LINE_BYTES - 1));
      last_addr = addr;
      queue_access(func, addr);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (access_backlog.size() != 0 || start) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (pending_reports.size() != 0) begin
      if (fault_count < 10) $display("%0d results never arrived", pending_reports.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
